// ===== rtl/psp_pkg.sv =====
// Package for the pending slot pool: sizes, codes, control types and helpers.
`default_nettype none
package psp_pkg;

  localparam int MAX_SLOTS = 64;
  localparam int MIN_SLOTS = 1;
  localparam int SLOT_AW   = $clog2(MAX_SLOTS);
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int CFG_W     = 7;
  localparam int HANDLE_W  = 31;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT     = 2'd0,
    CMD_GET     = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_NONE_PENDING = 2'd2,
    ST_NOT_FOUND    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SLOT_FREE    = 2'd0,
    SLOT_PENDING = 2'd1,
    SLOT_USING   = 2'd2
  } slot_state_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_DONE
  } fsm_state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic scan;
    logic commit;
    logic load_out;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic quick;
    logic hit;
    logic exhausted;
    logic out_free;
  } dp_sts_t;

  function automatic logic [CNT_W-1:0] clamp_cap(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (int'(v) < MIN_SLOTS) r = CNT_W'(MIN_SLOTS);
    else if (int'(v) > MAX_SLOTS) r = CNT_W'(MAX_SLOTS);
    else r = CNT_W'(v);
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/psp_if.sv =====
// Valid/ready channel interfaces for requests and responses of the slot pool.
`default_nettype none
interface psp_req_if;
  logic                          valid;
  logic                          ready;
  logic [psp_pkg::CMD_W-1:0]     command;
  logic [psp_pkg::HANDLE_W-1:0]  handle;

  modport source (output valid, output command, output handle, input ready);
  modport sink (input valid, input command, input handle, output ready);
endinterface

interface psp_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [psp_pkg::STATUS_W-1:0]  status;
  logic [psp_pkg::HANDLE_W-1:0]  handle_out;
  logic [psp_pkg::CNT_W-1:0]     occupied;

  modport source (output valid, output status, output handle_out, output occupied,
                  input ready);
  modport sink (input valid, input status, input handle_out, input occupied,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/psp_datapath.sv =====
// Slot pool datapath: slot memories, scan address/compare, counters, result register.
`default_nettype none
module psp_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [psp_pkg::CFG_W-1:0]       cfg_wdata,
  input  wire psp_pkg::dp_cmd_t                cmd,
  output      psp_pkg::dp_sts_t                sts,
  input  wire logic [psp_pkg::CMD_W-1:0]       req_command,
  input  wire logic [psp_pkg::HANDLE_W-1:0]    req_handle,
  input  wire logic                            rsp_ready,
  output      logic                            rsp_valid,
  output      logic [psp_pkg::STATUS_W-1:0]    rsp_status,
  output      logic [psp_pkg::HANDLE_W-1:0]    rsp_handle_out,
  output      logic [psp_pkg::CNT_W-1:0]       rsp_occupied
);

  psp_pkg::slot_state_t              state_mem [psp_pkg::MAX_SLOTS];
  logic [psp_pkg::HANDLE_W-1:0]      handle_mem [psp_pkg::MAX_SLOTS];
  logic [psp_pkg::MAX_SLOTS-1:0]     vld;

  logic [psp_pkg::CNT_W-1:0]         cap;
  logic [psp_pkg::CNT_W-1:0]         count;
  logic [psp_pkg::SLOT_AW-1:0]       ptr;

  psp_pkg::cmd_t                     cmd_q;
  logic [psp_pkg::HANDLE_W-1:0]      handle_q;

  logic [psp_pkg::SLOT_AW-1:0]       rd_idx;
  logic [psp_pkg::CNT_W-1:0]         issued;
  logic [psp_pkg::CNT_W-1:0]         checked;
  logic                              rd_pend;
  logic [psp_pkg::SLOT_AW-1:0]       rd_addr_q;
  psp_pkg::slot_state_t              rd_state_q;
  logic                              rd_vld_q;
  logic [psp_pkg::HANDLE_W-1:0]      rd_handle_q;

  logic [psp_pkg::SLOT_AW-1:0]       hit_addr;
  psp_pkg::status_t                  res_status;
  logic [psp_pkg::HANDLE_W-1:0]      res_handle;

  psp_pkg::cmd_t                     req_cmd;
  psp_pkg::slot_state_t              eff_state;
  psp_pkg::slot_state_t              new_state;
  psp_pkg::status_t                  miss_status;
  logic                              match;
  logic                              can_issue;
  logic [psp_pkg::SLOT_AW-1:0]       start_idx;
  logic [psp_pkg::SLOT_AW-1:0]       rd_idx_next;

  assign req_cmd   = psp_pkg::cmd_t'(req_command);
  assign eff_state = rd_vld_q ? rd_state_q : psp_pkg::SLOT_FREE;
  assign can_issue = issued < cap;
  assign start_idx = ({1'b0, ptr} < cap) ? ptr : '0;
  assign rd_idx_next = ({1'b0, rd_idx} == cap - psp_pkg::CNT_W'(1)) ? '0
                     : rd_idx + psp_pkg::SLOT_AW'(1);

  always_comb begin
    match       = 1'b0;
    new_state   = psp_pkg::SLOT_FREE;
    miss_status = psp_pkg::ST_OK;
    case (cmd_q)
      psp_pkg::CMD_PUT: begin
        match       = eff_state == psp_pkg::SLOT_FREE;
        new_state   = psp_pkg::SLOT_PENDING;
        miss_status = psp_pkg::ST_FULL;
      end
      psp_pkg::CMD_GET: begin
        match       = eff_state == psp_pkg::SLOT_PENDING;
        new_state   = psp_pkg::SLOT_USING;
        miss_status = psp_pkg::ST_NONE_PENDING;
      end
      psp_pkg::CMD_RELEASE: begin
        match       = (eff_state != psp_pkg::SLOT_FREE) && (rd_handle_q == handle_q);
        new_state   = psp_pkg::SLOT_FREE;
        miss_status = psp_pkg::ST_NOT_FOUND;
      end
      default: begin
        match = 1'b0;
      end
    endcase
  end

  assign sts.quick     = (req_cmd == psp_pkg::CMD_NOP)
                      || ((req_cmd == psp_pkg::CMD_PUT) && (count >= cap));
  assign sts.hit       = rd_pend && match;
  assign sts.exhausted = rd_pend && !match && (checked == cap - psp_pkg::CNT_W'(1));
  assign sts.out_free  = !rsp_valid || rsp_ready;

  // slot memories: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      state_mem[hit_addr] <= new_state;
      if (cmd_q == psp_pkg::CMD_PUT) begin
        handle_mem[hit_addr] <= handle_q;
      end
    end
    if (cmd.scan) begin
      rd_state_q  <= state_mem[rd_idx];
      rd_handle_q <= handle_mem[rd_idx];
    end
  end

  // slot valid bits: a slot not valid reads as free
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      vld <= '0;
    end else if (cmd.commit) begin
      if (cmd_q == psp_pkg::CMD_PUT) begin
        vld[hit_addr] <= 1'b1;
      end else if (cmd_q == psp_pkg::CMD_RELEASE) begin
        vld[hit_addr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap   <= psp_pkg::clamp_cap(psp_pkg::CFG_W'(psp_pkg::MAX_SLOTS));
      count <= '0;
      ptr   <= '0;
    end else if (cfg_we) begin
      cap   <= psp_pkg::clamp_cap(cfg_wdata);
      count <= '0;
      ptr   <= '0;
    end else if (cmd.commit) begin
      case (cmd_q)
        psp_pkg::CMD_PUT: begin
          count <= count + psp_pkg::CNT_W'(1);
          ptr   <= hit_addr;
        end
        psp_pkg::CMD_GET: begin
          ptr <= hit_addr;
        end
        psp_pkg::CMD_RELEASE: begin
          if (count != '0) begin
            count <= count - psp_pkg::CNT_W'(1);
          end
        end
        default: begin
          ptr <= ptr;
        end
      endcase
    end
  end

  // scan sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      issued  <= '0;
      checked <= '0;
      rd_idx  <= '0;
    end else if (cmd.accept) begin
      rd_pend <= 1'b0;
      issued  <= '0;
      checked <= '0;
      rd_idx  <= start_idx;
    end else if (cmd.scan) begin
      rd_pend <= can_issue;
      if (can_issue) begin
        issued <= issued + psp_pkg::CNT_W'(1);
        rd_idx <= rd_idx_next;
      end
      if (rd_pend) begin
        checked <= checked + psp_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_addr_q <= rd_idx;
      rd_vld_q  <= vld[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_q      <= req_cmd;
      handle_q   <= req_handle;
      res_handle <= '0;
      res_status <= (req_cmd == psp_pkg::CMD_PUT) ? psp_pkg::ST_FULL : psp_pkg::ST_OK;
    end else if (cmd.scan && sts.hit) begin
      hit_addr   <= rd_addr_q;
      res_status <= psp_pkg::ST_OK;
      res_handle <= (cmd_q == psp_pkg::CMD_GET) ? rd_handle_q : '0;
    end else if (cmd.scan && sts.exhausted) begin
      res_status <= miss_status;
      res_handle <= '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp_status     <= res_status;
      rsp_handle_out <= res_handle;
      rsp_occupied   <= count;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/psp_ctrl.sv =====
// Slot pool controller: sequences accept, slot scan, slot update and result load.
`default_nettype none
module psp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output      logic              req_ready,
  output      psp_pkg::dp_cmd_t  cmd,
  input  wire psp_pkg::dp_sts_t  sts
);

  psp_pkg::fsm_state_t state;
  psp_pkg::fsm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      psp_pkg::S_IDLE: begin
        if (req_valid) begin
          state_next = sts.quick ? psp_pkg::S_DONE : psp_pkg::S_SCAN;
        end
      end
      psp_pkg::S_SCAN: begin
        if (sts.hit) begin
          state_next = psp_pkg::S_UPDATE;
        end else if (sts.exhausted) begin
          state_next = psp_pkg::S_DONE;
        end
      end
      psp_pkg::S_UPDATE: begin
        state_next = psp_pkg::S_DONE;
      end
      psp_pkg::S_DONE: begin
        if (sts.out_free) begin
          state_next = psp_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = psp_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready    = 1'b0;
    cmd          = '0;
    case (state)
      psp_pkg::S_IDLE: begin
        req_ready  = 1'b1;
        cmd.accept = req_valid;
      end
      psp_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
      end
      psp_pkg::S_UPDATE: begin
        cmd.commit = 1'b1;
      end
      psp_pkg::S_DONE: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/pending_slot_pool_core.sv =====
// Pending slot pool top level: controller, datapath and channel hookup.
//
// Handle pool of psp_pkg::MAX_SLOTS slots, each free, pending or in use.
// req channel (valid/ready): command (put, get, release, nop) and handle.
// rsp channel (valid/ready): status, handle_out (get only) and occupied count.
// cfg_we/cfg_wdata write the capacity (clamped to 1..64) and empty the pool;
// write only while no request is in flight.
// Each get, release, or put into a pool that is not full scans the active
// slots circularly from the scan pointer, one slot per cycle through the
// registered read port of the slot memories. A nop or a put into a full pool
// skips the scan and goes straight to the result stage.
// One request is worked on at a time; the next request transfer is taken once
// the response is loaded into the output register, even while it still waits.
// A stalled response holds the pool in the result stage until the receiver
// takes it. Reset frees all slots at once, capacity 64, pointer and count zero.
`default_nettype none
module pending_slot_pool_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [psp_pkg::CFG_W-1:0]  cfg_wdata,
  psp_req_if.sink                         req,
  psp_rsp_if.source                       rsp
);

  psp_pkg::dp_cmd_t dp_cmd;
  psp_pkg::dp_sts_t dp_sts;

  psp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .cmd       (dp_cmd),
    .sts       (dp_sts)
  );

  psp_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .cmd            (dp_cmd),
    .sts            (dp_sts),
    .req_command    (req.command),
    .req_handle     (req.handle),
    .rsp_ready      (rsp.ready),
    .rsp_valid      (rsp.valid),
    .rsp_status     (rsp.status),
    .rsp_handle_out (rsp.handle_out),
    .rsp_occupied   (rsp.occupied)
  );

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while previous one still in flight");

  a_failed_no_handle: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status != psp_pkg::ST_OK) |-> rsp.handle_out == '0)
    else $error("failed operation returned a handle");

  a_reset_clean: assert property (@(posedge clk)
    rst |=> !rsp.valid && req.ready)
    else $error("pool not idle after reset");

  a_occupied_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.occupied <= psp_pkg::CNT_W'(psp_pkg::MAX_SLOTS))
    else $error("occupied count beyond pool size");

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for pending_slot_pool_core: random and directed put/get/release traffic.
`timescale 1ns / 100ps
module tb_top;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 75;
  localparam int STEADY_PHASE = 5;
  localparam int TAIL_CYCLES  = psp_pkg::MAX_SLOTS + 16;

  // capacity per phase (-1 picks one at random) and put weight in percent
  localparam int PHASE_CAP [PHASES] = '{1, 2, 3, 0, 127, 64, 5, 100, 8, -1, 33, 64};
  localparam int PHASE_PUT [PHASES] = '{45, 50, 45, 40, 50, 55, 45, 50, 45, 45, 50, 90};

  typedef struct {
    psp_pkg::status_t                st;
    logic [psp_pkg::HANDLE_W-1:0]    h;
    logic [psp_pkg::CNT_W-1:0]       occ;
  } pool_rsp_t;

  class pool_scoreboard;
    logic [psp_pkg::HANDLE_W-1:0] slot_h [psp_pkg::MAX_SLOTS];
    psp_pkg::slot_state_t         slot_st [psp_pkg::MAX_SLOTS];
    int unsigned                  ptr;
    int unsigned                  cnt;
    int unsigned                  cap;
    pool_rsp_t                    due [$];
    int                           errors;
    int                           n_status [4];

    function new();
      errors = 0;
      foreach (n_status[i]) n_status[i] = 0;
      cap = psp_pkg::MAX_SLOTS;
      empty_pool();
    endfunction

    function void empty_pool();
      foreach (slot_st[i]) begin
        slot_st[i] = psp_pkg::SLOT_FREE;
        slot_h[i]  = '0;
      end
      ptr = 0;
      cnt = 0;
    endfunction

    function void set_capacity(logic [psp_pkg::CFG_W-1:0] v);
      if (int'(v) < psp_pkg::MIN_SLOTS) cap = psp_pkg::MIN_SLOTS;
      else if (int'(v) > psp_pkg::MAX_SLOTS) cap = psp_pkg::MAX_SLOTS;
      else cap = v;
      empty_pool();
    endfunction

    function int unsigned slot_at(int unsigned k);
      int unsigned start;
      start = (ptr < cap) ? ptr : 0;
      return (start + k) % cap;
    endfunction

    function int outstanding();
      return due.size();
    endfunction

    // accepted request: advance the pool model and queue the expected response
    function void note_request(psp_pkg::cmd_t c, logic [psp_pkg::HANDLE_W-1:0] h);
      pool_rsp_t   e;
      int unsigned s;
      e.st = psp_pkg::ST_OK;
      e.h  = '0;
      case (c)
        psp_pkg::CMD_PUT: begin
          e.st = psp_pkg::ST_FULL;
          if (cnt < cap) begin
            for (int unsigned k = 0; k < cap; k++) begin
              s = slot_at(k);
              if (slot_st[s] == psp_pkg::SLOT_FREE) begin
                slot_h[s]  = h;
                slot_st[s] = psp_pkg::SLOT_PENDING;
                cnt++;
                ptr  = s;
                e.st = psp_pkg::ST_OK;
                break;
              end
            end
          end
        end
        psp_pkg::CMD_GET: begin
          e.st = psp_pkg::ST_NONE_PENDING;
          for (int unsigned k = 0; k < cap; k++) begin
            s = slot_at(k);
            if (slot_st[s] == psp_pkg::SLOT_PENDING) begin
              slot_st[s] = psp_pkg::SLOT_USING;
              ptr  = s;
              e.h  = slot_h[s];
              e.st = psp_pkg::ST_OK;
              break;
            end
          end
        end
        psp_pkg::CMD_RELEASE: begin
          e.st = psp_pkg::ST_NOT_FOUND;
          for (int unsigned k = 0; k < cap; k++) begin
            s = slot_at(k);
            if (slot_st[s] != psp_pkg::SLOT_FREE && slot_h[s] == h) begin
              slot_st[s] = psp_pkg::SLOT_FREE;
              if (cnt > 0) cnt--;
              e.st = psp_pkg::ST_OK;
              break;
            end
          end
        end
        default: ;
      endcase
      e.occ = psp_pkg::CNT_W'(cnt);
      n_status[int'(e.st)]++;
      due.push_back(e);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_response(logic [psp_pkg::STATUS_W-1:0] st,
                        logic [psp_pkg::HANDLE_W-1:0] h,
                        logic [psp_pkg::CNT_W-1:0] occ);
      pool_rsp_t e;
      if (due.size() == 0) begin
        report($sformatf("unexpected response status %0d", st));
      end else begin
        e = due.pop_front();
        if (st !== e.st)
          report($sformatf("status %0d, want %0d", st, e.st));
        if (h !== e.h)
          report($sformatf("handle_out 0x%08h, want 0x%08h", h, e.h));
        if (occ !== e.occ)
          report($sformatf("occupied %0d, want %0d", occ, e.occ));
      end
    endtask
  endclass

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         cfg_we;
  logic [psp_pkg::CFG_W-1:0]    cfg_wdata;
  bit                           steady;
  int                           cycles = 0;
  int                           n_items;
  int                           n_settings;
  logic [psp_pkg::HANDLE_W-1:0] put_log [$];
  pool_scoreboard               sb;

  psp_req_if req_ch ();
  psp_rsp_if rsp_ch ();

  pending_slot_pool_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // response side: random back-pressure, check every transfer
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_response(rsp_ch.status, rsp_ch.handle_out, rsp_ch.occupied);
      rsp_ch.ready <= steady || ($urandom_range(99) >= 9);
    end
  end

  task automatic send_req(psp_pkg::cmd_t c, logic [psp_pkg::HANDLE_W-1:0] h);
    if (!steady && $urandom_range(99) < 9) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.command <= c;
    req_ch.handle  <= h;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(c, h);
    n_items++;
  endtask

  task automatic write_capacity(logic [psp_pkg::CFG_W-1:0] v);
    req_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_capacity(v);
    put_log.delete();
    n_settings++;
  endtask

  function automatic logic [psp_pkg::HANDLE_W-1:0] rand_handle();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 5) return psp_pkg::HANDLE_W'($urandom);
    if (r < 8) return psp_pkg::HANDLE_W'($urandom_range(15));
    if (r == 8) return '0;
    return '1;
  endfunction

  task automatic random_item(int put_pct);
    int unsigned                  r;
    int unsigned                  idx;
    logic [psp_pkg::HANDLE_W-1:0] h;
    r = $urandom_range(99);
    if (r < 4) begin
      send_req(psp_pkg::CMD_NOP, rand_handle());
    end else if (r < 4 + put_pct) begin
      h = rand_handle();
      put_log.push_back(h);
      if (put_log.size() > psp_pkg::MAX_SLOTS) void'(put_log.pop_front());
      send_req(psp_pkg::CMD_PUT, h);
    end else if (r < 4 + put_pct + (96 - put_pct) / 2) begin
      send_req(psp_pkg::CMD_GET, rand_handle());
    end else begin
      if (put_log.size() > 0 && $urandom_range(99) < 85) begin
        idx = $urandom_range(put_log.size() - 1);
        h = put_log[idx];
        put_log.delete(idx);
      end else begin
        h = rand_handle();
      end
      send_req(psp_pkg::CMD_RELEASE, h);
    end
  endtask

  initial begin
    int cap_v;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    steady         = 1'b0;
    n_items        = 0;
    n_settings     = 0;
    req_ch.valid   = 1'b0;
    req_ch.command = psp_pkg::CMD_NOP;
    req_ch.handle  = '0;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty pool, extremes, duplicates, single slot
    send_req(psp_pkg::CMD_GET, '0);
    send_req(psp_pkg::CMD_RELEASE, 31'd5);
    send_req(psp_pkg::CMD_NOP, '1);
    send_req(psp_pkg::CMD_PUT, '0);
    send_req(psp_pkg::CMD_PUT, '1);
    send_req(psp_pkg::CMD_PUT, '0);
    send_req(psp_pkg::CMD_GET, '1);
    send_req(psp_pkg::CMD_GET, '0);
    send_req(psp_pkg::CMD_GET, '0);
    send_req(psp_pkg::CMD_GET, '0);
    send_req(psp_pkg::CMD_RELEASE, '0);
    send_req(psp_pkg::CMD_RELEASE, '0);
    send_req(psp_pkg::CMD_RELEASE, '0);
    send_req(psp_pkg::CMD_RELEASE, '1);
    write_capacity(7'd1);
    send_req(psp_pkg::CMD_PUT, 31'h2AAA_AAAA);
    send_req(psp_pkg::CMD_PUT, 31'h5555_5555);
    send_req(psp_pkg::CMD_RELEASE, 31'h5555_5555);
    send_req(psp_pkg::CMD_GET, '0);
    send_req(psp_pkg::CMD_GET, '0);
    send_req(psp_pkg::CMD_RELEASE, 31'h2AAA_AAAA);
    send_req(psp_pkg::CMD_NOP, '0);

    for (int p = 0; p < PHASES; p++) begin
      cap_v = (PHASE_CAP[p] < 0) ? $urandom_range(1, 127) : PHASE_CAP[p];
      write_capacity(psp_pkg::CFG_W'(cap_v));
      steady = (p == STEADY_PHASE);
      for (int i = 0; i < PHASE_ITEMS; i++) random_item(PHASE_PUT[p]);
    end
    req_ch.valid <= 1'b0;
    steady = 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d requests over %0d capacity writes", n_items, n_settings);
    $display("Responses: ok %0d, full %0d, nothing pending %0d, not found %0d",
             sb.n_status[psp_pkg::ST_OK], sb.n_status[psp_pkg::ST_FULL],
             sb.n_status[psp_pkg::ST_NONE_PENDING], sb.n_status[psp_pkg::ST_NOT_FOUND]);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
